/* rtl/lcd_pixel_write_sequencer_defines.svh */
// Assertion macros shared by the pixel write sequencer RTL.
`ifndef LCD_PIXEL_WRITE_SEQUENCER_DEFINES_SVH
`define LCD_PIXEL_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LPWS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lpws_pkg.sv */
// Types and constants of the LCD pixel write sequencer.
package lpws_pkg;

   // Pixel queue depth; must be a power of two so the pointers wrap.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Reset values of the command registers.
   localparam logic [7:0] PAGE_COMMAND_RST   = 8'd117;
   localparam logic [7:0] COLUMN_COMMAND_RST = 8'd21;
   localparam logic [7:0] WRITE_COMMAND_RST  = 8'd92;
   localparam logic [7:0] END_PAGE_RST       = 8'd131;
   localparam logic [7:0] END_COLUMN_RST     = 8'd131;

   typedef enum logic [2:0] {
      CSR_PANEL_MODE     = 3'd0,
      CSR_PAGE_COMMAND   = 3'd1,
      CSR_COLUMN_COMMAND = 3'd2,
      CSR_WRITE_COMMAND  = 3'd3,
      CSR_END_PAGE       = 3'd4,
      CSR_END_COLUMN     = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      STEP_PAGE_CMD  = 4'd0,
      STEP_X         = 4'd1,
      STEP_X_END     = 4'd2,
      STEP_COL_CMD   = 4'd3,
      STEP_Y         = 4'd4,
      STEP_Y_END     = 4'd5,
      STEP_WRITE_CMD = 4'd6,
      STEP_COLOR0    = 4'd7,
      STEP_COLOR1    = 4'd8,
      STEP_COLOR2    = 4'd9
   } step_type;

   typedef struct packed {
      logic [7:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [11:0] pixel_color;
      logic        panel_mode;
   } item_type;

   typedef struct packed {
      logic [7:0] page_command;
      logic [7:0] column_command;
      logic [7:0] write_command;
      logic [7:0] end_page;
      logic [7:0] end_column;
   } csr_type;

endpackage

/* rtl/lpws_front.sv */
// Front end: control registers and pixel intake into the queue.
module lpws_front
   import lpws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_pixel_y,
   input  logic [11:0] req_pixel_color,
   input  logic        q_full,
   output logic        q_push,
   output item_type    q_item,
   output csr_type     csr_regs
);

   logic    panel_mode_ff, panel_mode_in;
   csr_type csr_ff, csr_in;
   logic    csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      panel_mode_in = panel_mode_ff;
      csr_in        = csr_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_PANEL_MODE:     panel_mode_in         = csr_data[0];
            CSR_PAGE_COMMAND:   csr_in.page_command   = csr_data;
            CSR_COLUMN_COMMAND: csr_in.column_command = csr_data;
            CSR_WRITE_COMMAND:  csr_in.write_command  = csr_data;
            CSR_END_PAGE:       csr_in.end_page       = csr_data;
            CSR_END_COLUMN:     csr_in.end_column     = csr_data;
            default:            panel_mode_in         = panel_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_mode_ff         <= 1'b0;
         csr_ff.page_command   <= PAGE_COMMAND_RST;
         csr_ff.column_command <= COLUMN_COMMAND_RST;
         csr_ff.write_command  <= WRITE_COMMAND_RST;
         csr_ff.end_page       <= END_PAGE_RST;
         csr_ff.end_column     <= END_COLUMN_RST;
      end else begin
         panel_mode_ff <= panel_mode_in;
         csr_ff        <= csr_in;
      end
   end

   assign csr_regs = csr_ff;

   // Tag each pixel with the panel mode so the back end knows its word count.
   assign req_stall          = q_full;
   assign q_push             = req_valid && !q_full;
   assign q_item.pixel_x     = req_pixel_x;
   assign q_item.pixel_y     = req_pixel_y;
   assign q_item.pixel_color = req_pixel_color;
   assign q_item.panel_mode  = panel_mode_ff;

endmodule

/* rtl/lpws_queue.sv */
// Short pixel queue between front and back end.
module lpws_queue
   import lpws_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head_item,
   output logic     full,
   output logic     empty
);

`include "lcd_pixel_write_sequencer_defines.svh"

   item_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `LPWS_ASSERT_NOW(a_q_count_range, clock, reset, 1'b1, count_ff <= QCNT_W'(QDEPTH), "queue count beyond depth")
   `LPWS_ASSERT_NOW(a_q_no_pop_empty, clock, reset, pop, !empty, "pop from empty queue")
   `LPWS_ASSERT_NEXT(a_q_count_track, clock, reset, 1'b1, count_ff == $past(count_ff) + QCNT_W'($past(push)) - QCNT_W'($past(pop)), "queue count lost track")

endmodule

/* rtl/lpws_back.sv */
// Back end: walks one pixel's word sequence into the result register.
module lpws_back
   import lpws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  csr_type    csr_regs,
   input  logic       q_empty,
   input  item_type   q_item,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_data,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_last_word
);

`include "lcd_pixel_write_sequencer_defines.svh"

   step_type   step_ff, step_in;
   logic       cur_valid_ff, cur_valid_in;
   item_type   cur_ff, cur_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_is_data_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;

   logic       advance;
   logic       rsp_load;
   step_type   step_succ;
   logic       word_is_data;
   logic [7:0] word_byte;
   logic       word_last;
   logic [3:0] red, blue;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign red     = cur_ff.pixel_color[11:8];
   assign blue    = cur_ff.pixel_color[3:0];

   // Next state.
   always_comb begin
      case (step_ff)
         STEP_PAGE_CMD:  step_succ = STEP_X;
         STEP_X:         step_succ = STEP_X_END;
         STEP_X_END:     step_succ = STEP_COL_CMD;
         STEP_COL_CMD:   step_succ = STEP_Y;
         STEP_Y:         step_succ = STEP_Y_END;
         STEP_Y_END:     step_succ = STEP_WRITE_CMD;
         STEP_WRITE_CMD: step_succ = STEP_COLOR0;
         STEP_COLOR0:    step_succ = STEP_COLOR1;
         STEP_COLOR1:    step_succ = STEP_COLOR2;
         default:        step_succ = STEP_PAGE_CMD;
      endcase

      q_pop        = 1'b0;
      rsp_load     = 1'b0;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      if (cur_valid_ff) begin
         if (advance) begin
            rsp_load = 1'b1;
            if (word_last) begin
               // Pick up the next pixel in the same cycle: no gap between pixels.
               if (!q_empty) begin
                  q_pop   = 1'b1;
                  cur_in  = q_item;
                  step_in = STEP_PAGE_CMD;
               end else begin
                  cur_valid_in = 1'b0;
               end
            end else begin
               step_in = step_succ;
            end
         end
      end else if (!q_empty) begin
         q_pop        = 1'b1;
         cur_in       = q_item;
         cur_valid_in = 1'b1;
         step_in      = STEP_PAGE_CMD;
      end
   end

   // Word for the current step.
   always_comb begin
      word_is_data = 1'b1;
      word_last    = 1'b0;
      case (step_ff)
         STEP_PAGE_CMD: begin
            word_is_data = 1'b0;
            word_byte    = csr_regs.page_command;
         end
         STEP_X:     word_byte = cur_ff.pixel_x;
         STEP_X_END: word_byte = cur_ff.panel_mode ? cur_ff.pixel_x : csr_regs.end_page;
         STEP_COL_CMD: begin
            word_is_data = 1'b0;
            word_byte    = csr_regs.column_command;
         end
         STEP_Y:     word_byte = cur_ff.pixel_y;
         STEP_Y_END: word_byte = cur_ff.panel_mode ? cur_ff.pixel_y : csr_regs.end_column;
         STEP_WRITE_CMD: begin
            word_is_data = 1'b0;
            word_byte    = csr_regs.write_command;
         end
         STEP_COLOR0: word_byte = cur_ff.pixel_color[11:4];
         STEP_COLOR1: begin
            word_byte = cur_ff.panel_mode ? {blue, 4'h0} : {blue, red};
            word_last = cur_ff.panel_mode;
         end
         STEP_COLOR2: begin
            word_byte = cur_ff.pixel_color[7:0];
            word_last = 1'b1;
         end
         default: word_byte = 8'h00;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_PAGE_CMD;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (rsp_load) begin
         rsp_is_data_ff <= word_is_data;
         rsp_byte_ff    <= word_byte;
         rsp_last_ff    <= word_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_data    = rsp_is_data_ff;
   assign rsp_byte_value = rsp_byte_ff;
   assign rsp_last_word  = rsp_last_ff;

   `LPWS_ASSERT_NOW(a_bk_short_mode, clock, reset, cur_valid_ff && cur_ff.panel_mode, step_ff != STEP_COLOR2, "third colour word in second panel mode")
   `LPWS_ASSERT_NOW(a_bk_last_is_data, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_is_data_ff, "last word flagged as command")
   `LPWS_ASSERT_NEXT(a_bk_load_start, clock, reset, q_pop, cur_valid_ff && step_ff == STEP_PAGE_CMD, "loaded pixel does not start at page command")

endmodule

/* rtl/lcd_pixel_write_sequencer.sv */
// Top level of the LCD pixel write sequencer.
//
// Takes one pixel word (x, y, 12-bit color) on the req_ channel and returns
// the 9-bit SPI word sequence for it on the rsp_ channel, one word per cycle
// while rsp_stall is low: a data/command flag, a byte and a last-word flag on the final word.
// Panel mode 0 gives 10 words per pixel, panel mode 1 gives 9.
// The csr_ channel writes the panel mode and command bytes; csr_ready is
// always high; registers must be changed only while the block is idle, which the block does not enforce.
// A pixel is accepted when req_valid is high and req_stall low; req_stall
// rises only when the 4-entry pixel queue is full.
// The first word of a pixel passes through the queue, the back end's current
// pixel register and its result register. Throughput: one word per cycle
// while rsp_stall is low, from the single result register of the back end;
// consecutive pixels follow with no gap.
// When rsp_stall is high the current word holds and the sequence pauses;
// the queue keeps taking pixels until full.
// Reset (synchronous, active high) empties the queue, drops any sequence in
// progress and restores the register defaults.
module lcd_pixel_write_sequencer
   import lpws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_pixel_y,
   input  logic [11:0] req_pixel_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_data,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_last_word
);

   logic     q_push, q_pop, q_full, q_empty;
   item_type push_item, head_item;
   csr_type  csr_regs;

   lpws_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_pixel_color (req_pixel_color),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (push_item),
      .csr_regs        (csr_regs)
   );

   lpws_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   lpws_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_regs       (csr_regs),
      .q_empty        (q_empty),
      .q_item         (head_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_data    (rsp_is_data),
      .rsp_byte_value (rsp_byte_value),
      .rsp_last_word  (rsp_last_word)
   );

endmodule
